FILE: rtl/base64_line_wrapped_encoder_top_defines.svh
// Assertion macros shared by the checker of the line-wrapped Base64 encoder.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef BASE64_LINE_WRAPPED_ENCODER_TOP_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64LE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64le assertion failed");

// Next-cycle implication, checked outside reset.
`define B64LE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64le assertion failed");

// Next-cycle implication that also holds across reset.
`define B64LE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("b64le assertion failed");

`endif

FILE: rtl/b64le_pkg.sv
// Package of the line-wrapped Base64 encoder: types, constants, alphabet.
// Depends on nothing; used by every module of the block and by the character channel.
package b64le_pkg;

    typedef logic [6:0] t_char;
    typedef logic [5:0] t_sextet;

    localparam int unsigned CMD_CHARS = 4;
    localparam int unsigned IDX_W     = $clog2(CMD_CHARS);
    // Queue depth must be a power of two so pointers wrap on their own.
    localparam int unsigned QDEPTH    = 2;
    localparam int unsigned QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    localparam t_char CHAR_PAD = 7'd61;
    localparam t_char CHAR_CR  = 7'd13;
    localparam t_char CHAR_LF  = 7'd10;

    localparam logic [6:0] LINE_LEN_RESET = 7'd76;
    localparam logic [6:0] LINE_LEN_MIN   = 7'd2;

    typedef enum logic [1:0] {
        PH_ZERO = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BK_CHAR = 2'd0,
        BK_CR   = 2'd1,
        BK_LF   = 2'd2
    } t_back_state;

    // One accepted byte, already turned into the symbols it completes.
    typedef struct packed {
        logic [IDX_W-1:0]        last_idx;
        logic                    fin;
        t_char [CMD_CHARS-1:0]   chars;
    } t_cmd;

    // Standard Base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic t_char b64_symbol(input t_sextet v);
        t_char w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            return w + 7'd65;
        end else if (v < 6'd52) begin
            return w + 7'd71;
        end else if (v < 6'd62) begin
            return w - 7'd4;
        end else if (v == 6'd62) begin
            return 7'd43;
        end else begin
            return 7'd47;
        end
    endfunction

endpackage

FILE: rtl/b64le_ifs.sv
// Handshake channels of the line-wrapped Base64 encoder: byte in, char out, config.
// Depends on b64le_pkg for the character type.
interface b64le_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b64le_char_if;
    logic                valid;
    logic                ready;
    b64le_pkg::t_char    out_char;
    logic                run_end;
    modport source (output valid, out_char, run_end, input ready);
    modport sink   (input valid, out_char, run_end, output ready);
endinterface

interface b64le_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] line_length;
    modport source (output valid, line_length, input ready);
    modport sink   (input valid, line_length, output ready);
endinterface

FILE: rtl/b64le_front.sv
// Front end: accepts bytes, tracks group phase and leftover bits, builds commands.
// Depends on b64le_pkg and the byte channel interface.
module b64le_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64le_byte_if.sink        i_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output b64le_pkg::t_cmd   o_cmd
);
    import b64le_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left, n_left;
    logic [7:0] b;

    assign b             = i_byte.data_byte;
    assign i_byte.ready  = !i_q_full;
    assign o_push        = i_byte.valid && !i_q_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.fin      = i_byte.final_byte;
        o_cmd.chars[1] = CHAR_PAD;
        o_cmd.chars[2] = CHAR_PAD;
        o_cmd.chars[3] = CHAR_PAD;
        n_left         = r_left;
        n_phase        = r_phase;
        unique case (r_phase)
            PH_ONE: begin
                o_cmd.chars[0] = b64_symbol({r_left[1:0], b[7:4]});
                n_left         = b[3:0];
                n_phase        = PH_TWO;
                if (i_byte.final_byte) begin
                    o_cmd.chars[1] = b64_symbol({b[3:0], 2'b00});
                    o_cmd.last_idx = IDX_W'(2);
                end else begin
                    o_cmd.last_idx = IDX_W'(0);
                end
            end
            PH_TWO: begin
                o_cmd.chars[0] = b64_symbol({r_left, b[7:6]});
                o_cmd.chars[1] = b64_symbol(b[5:0]);
                o_cmd.last_idx = IDX_W'(1);
                n_left         = 4'd0;
                n_phase        = PH_ZERO;
            end
            default: begin
                // Phase zero, and the unused phase code that behaves like it.
                o_cmd.chars[0] = b64_symbol(b[7:2]);
                n_left         = {2'b00, b[1:0]};
                n_phase        = PH_ONE;
                if (i_byte.final_byte) begin
                    o_cmd.chars[1] = b64_symbol({b[1:0], 4'b0000});
                    o_cmd.last_idx = IDX_W'(3);
                end else begin
                    o_cmd.last_idx = IDX_W'(0);
                end
            end
        endcase
        if (i_byte.final_byte) begin
            n_left  = 4'd0;
            n_phase = PH_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ZERO;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

FILE: rtl/b64le_queue.sv
// Short command queue between the front and the back of the encoder.
// Depends on b64le_pkg for the command type and the queue depth.
module b64le_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64le_pkg::t_cmd   i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output b64le_pkg::t_cmd   o_head
);
    import b64le_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/b64le_back.sv
// Back end: one char per cycle unless stalled; keeps the column, adds CR LF.
// Depends on b64le_pkg and the character channel interface.
module b64le_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_line_length,
    input  logic              i_q_valid,
    input  b64le_pkg::t_cmd   i_head,
    output logic              o_pop,
    b64le_char_if.source      o_char
);
    import b64le_pkg::*;

    t_back_state       r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [6:0]        r_col, n_col;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_char             r_out_char, n_out_char;
    logic              r_out_end, n_out_end;

    logic [6:0] eff_len;
    logic [6:0] col_inc;
    logic       wrap;
    logic       last_char;
    logic       load;
    logic       step;

    assign eff_len   = (i_line_length < LINE_LEN_MIN) ? LINE_LEN_MIN : i_line_length;
    assign col_inc   = r_col + 7'd1;
    assign wrap      = (col_inc >= eff_len);
    assign last_char = (r_idx == i_head.last_idx);
    assign load      = !r_out_valid || o_char.ready;
    assign step      = load && i_q_valid;

    assign o_char.valid    = r_out_valid;
    assign o_char.out_char = r_out_char;
    assign o_char.run_end  = r_out_end;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_col       = r_col;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_end   = r_out_end;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = 1'b0;
        end
        if (step) begin
            n_out_valid = 1'b1;
            n_out_end   = 1'b0;
            unique case (r_state)
                BK_CHAR: begin
                    n_out_char = i_head.chars[r_idx];
                    if (wrap) begin
                        n_col   = 7'd0;
                        n_state = BK_CR;
                        n_last  = last_char;
                    end else if (last_char && i_head.fin && col_inc != 7'd0) begin
                        n_col   = 7'd0;
                        n_state = BK_CR;
                        n_last  = 1'b1;
                    end else if (last_char) begin
                        n_col     = i_head.fin ? 7'd0 : col_inc;
                        n_out_end = 1'b1;
                        n_idx     = '0;
                        o_pop     = 1'b1;
                    end else begin
                        n_col = col_inc;
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                BK_CR: begin
                    n_out_char = CHAR_CR;
                    n_state    = BK_LF;
                end
                BK_LF: begin
                    n_out_char = CHAR_LF;
                    n_out_end  = r_last;
                    n_state    = BK_CHAR;
                    if (r_last) begin
                        n_idx = '0;
                        o_pop = 1'b1;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                default: begin
                    n_state = BK_CHAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CHAR;
            r_idx       <= '0;
            r_col       <= 7'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_col       <= n_col;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_end  <= n_out_end;
    end

endmodule

FILE: rtl/base64_line_wrapped_encoder_top.sv
// Top level of the line-wrapped Base64 encoder: config register, front, queue, back.
// Depends on b64le_pkg, b64le_ifs, b64le_front, b64le_queue and b64le_back.
//
//  Channel  | Dir | Payload                     | Transfer when
//  ---------+-----+-----------------------------+------------------------------
//  i_byte   | in  | data_byte[7:0], final_byte  | i_byte.valid && i_byte.ready
//  o_char   | out | out_char[6:0], run_end      | o_char.valid && o_char.ready
//  i_cfg    | in  | line_length[6:0]            | i_cfg.valid && i_cfg.ready
//
// Each byte produces 1 to 10 characters, about 1.4 on average under a steady stream.
// The single output register moves one character per cycle while the receiver is
// ready, and so sets the pace of the whole block.
// A byte is taken in any cycle in which the two-entry command queue has room,
// so the input keeps flowing while the output stalls until the queue fills.
// Reset is synchronous and active low; the config channel is always ready.
module base64_line_wrapped_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64le_byte_if.sink  i_byte,
    b64le_cfg_if.sink   i_cfg,
    b64le_char_if.source o_char
);
    import b64le_pkg::*;

    // Line length register. Values below two are clamped where they are used.
    logic [6:0] r_line_length;

    // Front to queue and queue to back.
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_line_length <= i_cfg.line_length;
        end
    end

    // The front turns each accepted byte into the one to four symbols it
    // completes, padding included, and tracks the position in the group.
    b64le_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    // The queue lets the front take new bytes while the back still drains
    // the characters of earlier ones.
    b64le_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (push_cmd),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (head_cmd)
    );

    // The back walks the symbols of the head command, counts the column,
    // inserts CR LF on a full line and closes a message with CR LF.
    b64le_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_length (r_line_length),
        .i_q_valid     (q_valid),
        .i_head        (head_cmd),
        .o_pop         (q_pop),
        .o_char        (o_char)
    );

endmodule

FILE: rtl/b64le_checker.sv
// Port-level checker for the line-wrapped Base64 encoder, bound to the top level.
// Depends on b64le_pkg and base64_line_wrapped_encoder_top_defines.svh.
`include "base64_line_wrapped_encoder_top_defines.svh"

module b64le_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input b64le_pkg::t_char i_out_char,
    input logic             i_run_end
);
    import b64le_pkg::*;

    // Nothing leaves the block in the cycle after reset.
    `B64LE_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)

    // A stalled result keeps its value.
    `B64LE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_char) && $stable(i_run_end))

    // A carriage return never ends the results of a byte.
    `B64LE_ASSERT_NOW(a_cr_not_end, i_clk, i_rst_n, i_out_valid && i_out_char == CHAR_CR, !i_run_end)

    // A line feed follows a transferred carriage return at once.
    `B64LE_ASSERT_NEXT(a_cr_then_lf, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_char == CHAR_CR, i_out_valid && i_out_char == CHAR_LF)

endmodule

bind base64_line_wrapped_encoder_top b64le_checker u_b64le_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_char.valid),
    .i_out_ready (o_char.ready),
    .i_out_char  (o_char.out_char),
    .i_run_end   (o_char.run_end)
);

FILE: tb/sv/tb_base64_line_wrapped_encoder_top.sv
// Testbench for the line-wrapped Base64 encoder: directed table, then random messages.
// Depends on b64le_pkg, the b64le_ifs interfaces and base64_line_wrapped_encoder_top.
// Every character leaving the block is checked against a cycle-free predictor of the encoding.
module tb_base64_line_wrapped_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64le_pkg::*;

    // Cycles in a row without any transfer on any channel before the run is abandoned.
    // The longest legal quiet spell is the deliberate receiver hold-off of HOLD_CYCLES.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 300;
    // Settling time after the last expected character before a register write or the verdict.
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned DIRECTED_ROWS  = 25;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS    = 53;
    localparam int unsigned MAX_PRINTED    = 30;

    // The alphabet packed as a string: the symbol for sextet v sits at byte 63 - v.
    localparam logic [8*64-1:0] B64_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic {
        ROW_BYTE = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    // One row of stimulus. A byte row may carry its expected characters as text (first
    // character leftmost), optionally followed by CR LF; otherwise the predictor decides.
    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  val;
        logic        fin;
        logic        typed;
        logic [2:0]  n_text;
        logic        crlf;
        logic [31:0] text;
    } t_row;

    // One expected output character together with its end-of-byte marker.
    typedef struct packed {
        t_char ch;
        logic  last;
    } t_out;

    logic i_clk;
    logic i_rst_n;

    b64le_byte_if byte_bus ();
    b64le_char_if char_bus ();
    b64le_cfg_if  cfg_bus ();

    base64_line_wrapped_encoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .i_cfg   (cfg_bus),
        .o_char  (char_bus)
    );

    // The directed table. The first rows start from reset with the default line length,
    // so their characters can be written down directly; later rows go to the predictor.
    t_row directed_rows [0:DIRECTED_ROWS-1] = '{
        // Single zero byte, then single all-ones byte: both flush with two pad characters.
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 3'd4, 1'b1, "AA=="},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 3'd4, 1'b1, "/w=="},
        // A full group of all-ones bytes, then one of zero bytes: no padding, closing CR LF.
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 3'd1, 1'b0, "/"},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 3'd1, 1'b0, "/"},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 3'd2, 1'b1, "//"},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 3'd1, 1'b0, "A"},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 3'd1, 1'b0, "A"},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 3'd2, 1'b1, "AA"},
        // Line of exactly four: the wrap lands on the last character, no closing CR LF.
        '{ROW_CFG,  8'd4,  1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h4D, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h61, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h6E, 1'b1, 1'b0, 3'd0, 1'b0, 32'd0},
        // A line length of one behaves as two: the densest bursts of characters.
        '{ROW_CFG,  8'd1,  1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'hA5, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h5A, 1'b1, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h3C, 1'b1, 1'b0, 3'd0, 1'b0, 32'd0},
        // A line length of zero behaves as two as well.
        '{ROW_CFG,  8'd0,  1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h81, 1'b1, 1'b0, 3'd0, 1'b0, 32'd0},
        // Longest lines, then the length is cut below the current column mid-message.
        '{ROW_CFG,  8'd127, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h12, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h34, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h56, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h78, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_CFG,  8'd3,  1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
        '{ROW_BYTE, 8'h9A, 1'b1, 1'b0, 3'd0, 1'b0, 32'd0}
    };

    // Predictor state: the register copy and the encoder's own state.
    logic [6:0]  enc_len;
    logic [3:0]  enc_left;
    t_phase      enc_phase;
    logic [6:0]  enc_col;

    // Characters produced by the byte being predicted, and the queue of those still owed.
    t_out        step_buf [0:7];
    int unsigned step_n;
    t_out        expected_chars [$];

    // The row currently offered on the byte channel, read back when its transfer happens.
    t_row        offer_row;

    int unsigned err_count;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_req;
    int unsigned hold_left;
    t_out        mon_head;
    logic        mon_xfer;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        if (err_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch, %s: expected %0d, got %0d", $time, what, want, got);
        end
        err_count++;
    endtask

    // Characters and line breaks of one byte go into step_buf in order.
    task automatic emit_raw(input t_char c);
        if (step_n < 8) begin
            step_buf[step_n] = '{ch: c, last: 1'b0};
        end
        step_n++;
    endtask

    // A visible character advances the column; a full line is closed with CR LF at once,
    // which also covers a column left beyond a freshly shortened line.
    task automatic emit_text(input t_char c);
        logic [6:0] eff;
        eff = (enc_len < LINE_LEN_MIN) ? LINE_LEN_MIN : enc_len;
        emit_raw(c);
        enc_col = enc_col + 7'd1;
        if (enc_col >= eff) begin
            emit_raw(CHAR_CR);
            emit_raw(CHAR_LF);
            enc_col = 7'd0;
        end
    endtask

    task automatic emit_sextet(input logic [5:0] v);
        emit_text(t_char'(B64_ALPHA[8*(63 - int'(v)) +: 7]));
    endtask

    // The predictor: the characters one input byte completes, and on the final byte the
    // flush of the partial sextet, the padding and the closing line break.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        step_n = 0;
        case (enc_phase)
            PH_ONE: begin
                emit_sextet({enc_left[1:0], b[7:4]});
                enc_left  = b[3:0];
                enc_phase = PH_TWO;
            end
            PH_TWO: begin
                emit_sextet({enc_left, b[7:6]});
                emit_sextet(b[5:0]);
                enc_left  = 4'd0;
                enc_phase = PH_ZERO;
            end
            default: begin
                // The unused phase value behaves as the start of a group.
                emit_sextet(b[7:2]);
                enc_left  = {2'b00, b[1:0]};
                enc_phase = PH_ONE;
            end
        endcase
        if (fin) begin
            if (enc_phase == PH_ONE) begin
                emit_sextet({enc_left[1:0], 4'b0000});
                emit_text(CHAR_PAD);
                emit_text(CHAR_PAD);
            end else if (enc_phase == PH_TWO) begin
                emit_sextet({enc_left, 2'b00});
                emit_text(CHAR_PAD);
            end
            if (enc_col != 7'd0) begin
                emit_raw(CHAR_CR);
                emit_raw(CHAR_LF);
            end
            enc_left  = 4'd0;
            enc_phase = PH_ZERO;
            enc_col   = 7'd0;
        end
    endtask

    // Monitor. Everything is sampled at the rising edge, where the inputs have been stable
    // since the falling edge and the block's outputs still show their pre-edge values.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enc_len      = LINE_LEN_RESET;
            enc_left     = 4'd0;
            enc_phase    = PH_ZERO;
            enc_col      = 7'd0;
            quiet_cycles = 0;
        end else begin
            mon_xfer = 1'b0;

            // Output transfer: compare against the oldest character still owed.
            if (char_bus.valid && char_bus.ready) begin
                mon_xfer = 1'b1;
                if (expected_chars.size() == 0) begin
                    report("character with nothing pending", 0, char_bus.out_char);
                end else begin
                    mon_head = expected_chars.pop_front();
                    if (char_bus.out_char !== mon_head.ch) begin
                        report("out_char", mon_head.ch, char_bus.out_char);
                    end
                    if (char_bus.run_end !== mon_head.last) begin
                        report("run_end", mon_head.last, char_bus.run_end);
                    end
                end
            end

            // Register write transfer: the predictor follows the new line length.
            if (cfg_bus.valid && cfg_bus.ready) begin
                mon_xfer = 1'b1;
                enc_len  = cfg_bus.line_length;
            end

            // Byte transfer: predict, or take the typed characters of a directed row while
            // still stepping the predictor so that its state stays in line with the block.
            if (byte_bus.valid && byte_bus.ready) begin
                mon_xfer = 1'b1;
                encode_byte(byte_bus.data_byte, byte_bus.final_byte);
                if (offer_row.typed) begin
                    step_n = 0;
                    for (int i = 0; i < int'(offer_row.n_text); i++) begin
                        step_buf[step_n] = '{
                            ch: t_char'(offer_row.text[8*(int'(offer_row.n_text) - 1 - i) +: 7]),
                            last: 1'b0
                        };
                        step_n++;
                    end
                    if (offer_row.crlf) begin
                        emit_raw(CHAR_CR);
                        emit_raw(CHAR_LF);
                    end
                end
                // Every byte causes at least one character; the last one closes the byte.
                step_buf[step_n - 1].last = 1'b1;
                for (int i = 0; i < int'(step_n); i++) begin
                    expected_chars = {expected_chars, step_buf[i]};
                end
            end

            quiet_cycles = mon_xfer ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: a long spell without any transfer means the block has hung.
    initial begin
        @(posedge i_rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("tb_base64_line_wrapped_encoder_top: done, errors");
        $finish;
    end

    // Receiver. Ready changes at the falling edge: held low for a requested hold-off,
    // otherwise dropped at random at the stall rate of the current phase.
    initial begin
        char_bus.ready = 1'b0;
        hold_left      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                char_bus.ready = 1'b0;
                hold_left--;
            end else begin
                char_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offers one byte after a random gap and returns at the falling edge after its transfer.
    // Valid stays high on return, so back-to-back bytes need no second assignment.
    task automatic send_byte(input t_row r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        offer_row           = r;
        byte_bus.valid      = 1'b1;
        byte_bus.data_byte  = r.val;
        byte_bus.final_byte = r.fin;
        do begin
            @(posedge i_clk);
        end while (!byte_bus.ready);
        @(negedge i_clk);
    endtask

    // Waits at falling edges until every owed character has arrived, then lets the block settle.
    task automatic wait_drained();
        while (expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // The line length is only written while the block has nothing in flight.
    task automatic write_cfg(input logic [6:0] len);
        byte_bus.valid = 1'b0;
        wait_drained();
        cfg_bus.valid       = 1'b1;
        cfg_bus.line_length = len;
        do begin
            @(posedge i_clk);
        end while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    initial begin
        t_row        row;
        int unsigned msg_left;
        int unsigned mode;
        logic [6:0]  len;
        logic [7:0]  b;

        // Every input of the block is known from time zero.
        i_rst_n             = 1'b0;
        byte_bus.valid      = 1'b0;
        byte_bus.data_byte  = 8'h00;
        byte_bus.final_byte = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.line_length = 7'd0;
        offer_row           = '0;
        err_count           = 0;
        quiet_cycles        = 0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_req            = 0;
        msg_left            = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part, streamed without gaps on either side.
        for (int i = 0; i < int'(DIRECTED_ROWS); i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                write_cfg(row.val[6:0]);
            end else begin
                send_byte(row);
            end
        end

        // Random part: messages of random length, mostly short, now and then long. A phase
        // may end in the middle of a message, so a new line length can meet a partial line.
        for (int p = 0; p < int'(RANDOM_PHASES); p++) begin
            case (p)
                0: begin
                    len = 7'd127;
                end
                1: begin
                    len = 7'd1;
                end
                2: begin
                    len = 7'd0;
                end
                3: begin
                    len = 7'd2;
                end
                4: begin
                    len = 7'($urandom_range(3, 20));
                end
                5: begin
                    len = LINE_LEN_RESET;
                end
                6: begin
                    len = 7'd4;
                end
                default: begin
                    len = 7'($urandom_range(3, 126));
                end
            endcase
            write_cfg(len);

            // Idle pattern of the phase: none, sender only, receiver only, then both lightly.
            mode           = p % 4;
            send_idle_pct  = (mode == 1) ? 81 : ((mode == 3) ? 9 : 0);
            recv_stall_pct = (mode == 2) ? 81 : ((mode == 3) ? 9 : 0);

            for (int k = 0; k < int'(PHASE_ITEMS); k++) begin
                if (msg_left == 0) begin
                    msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 9);
                end
                if ($urandom_range(0, 3) == 0) begin
                    b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                row = '{ROW_BYTE, b, (msg_left == 1), 1'b0, 3'd0, 1'b0, 32'd0};
                msg_left--;
                // In the first gap-free phase the receiver holds off for a long stretch while
                // bytes keep coming, so the block fills and must stall its input.
                if (p == 0 && k == 20) begin
                    hold_req = HOLD_CYCLES;
                end
                send_byte(row);
            end
        end

        byte_bus.valid = 1'b0;
        wait_drained();

        if (err_count == 0) begin
            $display("tb_base64_line_wrapped_encoder_top: done, clean");
        end else begin
            $display("tb_base64_line_wrapped_encoder_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/b64le_pkg.sv
rtl/b64le_ifs.sv
rtl/b64le_front.sv
rtl/b64le_queue.sv
rtl/b64le_back.sv
rtl/base64_line_wrapped_encoder_top.sv
rtl/b64le_checker.sv
tb/sv/tb_base64_line_wrapped_encoder_top.sv
